// ===== hdl/ospq_pkg.sv =====
`default_nettype none

package ospq_pkg;

    localparam int VALUE_W = 32;
    localparam int HELD_W  = 5;

    // Operation codes carried on the op field.
    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_SEARCH = 2'd1;
    localparam logic [1:0] OP_POPMIN = 2'd2;

    // Result status codes.
    localparam logic [1:0] ST_DONE  = 2'd0;
    localparam logic [1:0] ST_MISS  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;
    localparam logic [1:0] ST_FULL  = 2'd3;

    localparam logic signed [VALUE_W-1:0] EMPTY_VALUE = -32'sd1;

    // Command broadcast to every cell of the chain.
    typedef struct packed {
        logic ins;
        logic pop;
    } t_cell_cmd;

endpackage

`default_nettype wire

// ===== hdl/ospq_cell.sv =====
`default_nettype none

module ospq_cell (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 i_cmp_en,
    input  wire logic signed [ospq_pkg::VALUE_W-1:0]  i_cmp_value,
    input  wire ospq_pkg::t_cell_cmd                  i_cmd,
    input  wire logic signed [ospq_pkg::VALUE_W-1:0]  i_ins_value,
    input  wire logic signed [ospq_pkg::VALUE_W-1:0]  i_left_value,
    input  wire logic                                 i_left_valid,
    input  wire logic                                 i_left_lt,
    input  wire logic signed [ospq_pkg::VALUE_W-1:0]  i_right_value,
    input  wire logic                                 i_right_valid,
    output logic signed [ospq_pkg::VALUE_W-1:0]       o_value,
    output logic                                      o_valid,
    output logic                                      o_lt,
    output logic                                      o_eq
);
    import ospq_pkg::*;

    logic signed [VALUE_W-1:0] r_value;
    logic                      r_valid;
    logic                      r_lt;
    logic                      r_eq;

    // The compare flags are captured when a beat is taken and stay put until
    // the operation executes, since the stored entries do not move before then.
    always_ff @(posedge i_clk) begin
        if (i_cmp_en) begin
            r_lt <= r_valid && (r_value < i_cmp_value);
            r_eq <= r_valid && (r_value == i_cmp_value);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_cmd.pop) begin
            r_valid <= i_right_valid;
        end else if (i_cmd.ins && !r_lt) begin
            r_valid <= i_left_lt ? 1'b1 : i_left_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.pop) begin
            r_value <= i_right_value;
        end else if (i_cmd.ins && !r_lt) begin
            r_value <= i_left_lt ? i_ins_value : i_left_value;
        end
    end

    assign o_value = r_value;
    assign o_valid = r_valid;
    assign o_lt    = r_lt;
    assign o_eq    = r_eq;

endmodule

`default_nettype wire

// ===== hdl/ordered_set_insert_search_popmin.sv =====
// Ordered set of distinct signed 32-bit values with insert, search and pop-min.
//
// Input channel (i_in_valid / o_in_stall) carries one beat per operation:
// i_op selects insert, search or pop-min and i_value is the operand. Output
// channel (o_out_valid / i_out_stall) returns exactly one beat per operation
// with a status code, the result value and the number of values held after it.
//
// The values live in a chain of CAPACITY cells kept in ascending order. When a
// beat is taken every cell compares its entry with the operand and registers
// the outcome. In the next cycle the operation executes: an insert shifts the
// cells at and above the insertion point up by one, a pop shifts every cell
// down by one, and the result is loaded into the output register, from which
// it is offered on the output channel. No new beat is accepted until the
// pending operation has executed, since each operation makes a compare pass
// and then a shift pass over the cell chain.
//
// A new beat is accepted while an earlier result still waits in the output
// register. If the receiver keeps stalling, the pending operation waits in the
// execute cycle and o_in_stall stays high. Reset (synchronous, active low)
// empties the set and drops any pending result; no clearing pass is needed.
`default_nettype none

module ordered_set_insert_search_popmin #(
    parameter int CAPACITY = 16
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 i_in_valid,
    output logic                                      o_in_stall,
    input  wire logic [1:0]                           i_op,
    input  wire logic signed [ospq_pkg::VALUE_W-1:0]  i_value,
    output logic                                      o_out_valid,
    input  wire logic                                 i_out_stall,
    output logic [1:0]                                o_status,
    output logic signed [ospq_pkg::VALUE_W-1:0]       o_result_value,
    output logic [ospq_pkg::HELD_W-1:0]               o_held_count
);
    import ospq_pkg::*;

    // The count must be able to hold CAPACITY itself.
    localparam int CW = $clog2(CAPACITY + 1);
    localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } t_state;

    t_state                    r_state;
    logic [1:0]                r_op;
    logic signed [VALUE_W-1:0] r_val;
    logic [CW-1:0]             r_count;
    logic                      r_out_valid;
    logic [1:0]                r_out_status;
    logic signed [VALUE_W-1:0] r_out_value;
    logic [HELD_W-1:0]         r_out_count;

    logic [1:0]                n_status;
    logic signed [VALUE_W-1:0] n_value;
    logic [CW-1:0]             n_count;
    logic [CW+HELD_W-1:0]      w_count_ext;

    logic                      w_in_accept;
    logic                      w_out_free;
    logic                      w_fire;
    logic                      w_found;
    t_cell_cmd                 w_cmd;
    t_cell_cmd                 w_cell_cmd;

    logic signed [VALUE_W-1:0] w_cell_value [CAPACITY];
    logic [CAPACITY-1:0]       w_cell_valid;
    logic [CAPACITY-1:0]       w_cell_lt;
    logic [CAPACITY-1:0]       w_cell_eq;

    assign o_in_stall  = (r_state == S_EXEC);
    assign w_in_accept = i_in_valid && !o_in_stall;
    // The output register can take a new result if empty or being drained.
    assign w_out_free  = !r_out_valid || !i_out_stall;
    assign w_fire      = (r_state == S_EXEC) && w_out_free;

    // At most one valid cell can equal the operand, since the set is distinct.
    assign w_found = |w_cell_eq;

    // Operation decode in the execute cycle.
    always_comb begin
        w_cmd    = '0;
        n_status = ST_MISS;
        n_value  = r_val;
        n_count  = r_count;
        unique case (r_op)
            OP_INSERT: begin
                if (w_found) begin
                    n_status = ST_MISS;
                end else if (r_count >= CAP_C) begin
                    n_status = ST_FULL;
                end else begin
                    w_cmd.ins = 1'b1;
                    n_status  = ST_DONE;
                    n_count   = r_count + CW'(1);
                end
            end
            OP_SEARCH: begin
                n_status = w_found ? ST_DONE : ST_MISS;
            end
            OP_POPMIN: begin
                if (r_count == '0) begin
                    n_status = ST_EMPTY;
                    n_value  = EMPTY_VALUE;
                end else begin
                    w_cmd.pop = 1'b1;
                    n_status  = ST_DONE;
                    n_value   = w_cell_value[0];
                    n_count   = r_count - CW'(1);
                end
            end
            default: begin
                n_status = ST_MISS;
            end
        endcase
    end

    // Only let the cells move when the operation actually retires.
    always_comb begin
        w_cell_cmd     = w_cmd;
        w_cell_cmd.ins = w_cmd.ins && w_fire;
        w_cell_cmd.pop = w_cmd.pop && w_fire;
    end

    // The reported count is the held count taken modulo 32.
    assign w_count_ext = {{HELD_W{1'b0}}, n_count};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_in_accept) begin
                        r_state <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    if (w_out_free) begin
                        r_state      <= S_IDLE;
                        r_count      <= n_count;
                        r_out_valid  <= 1'b1;
                        r_out_status <= n_status;
                        r_out_value  <= n_value;
                        r_out_count  <= w_count_ext[HELD_W-1:0];
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_accept) begin
            r_op  <= i_op;
            r_val <= i_value;
        end
    end

    // The cell chain. The cell below the first acts as a boundary that is
    // "less than" everything, and the cell past the last is always empty.
    for (genvar gi = 0; gi < CAPACITY; gi++) begin : g_cell
        logic signed [VALUE_W-1:0] w_left_value;
        logic                      w_left_valid;
        logic                      w_left_lt;
        logic signed [VALUE_W-1:0] w_right_value;
        logic                      w_right_valid;

        if (gi == 0) begin : g_first
            assign w_left_value = r_val;
            assign w_left_valid = 1'b0;
            assign w_left_lt    = 1'b1;
        end else begin : g_mid
            assign w_left_value = w_cell_value[gi-1];
            assign w_left_valid = w_cell_valid[gi-1];
            assign w_left_lt    = w_cell_lt[gi-1];
        end

        if (gi == CAPACITY - 1) begin : g_last
            assign w_right_value = r_val;
            assign w_right_valid = 1'b0;
        end else begin : g_inner
            assign w_right_value = w_cell_value[gi+1];
            assign w_right_valid = w_cell_valid[gi+1];
        end

        ospq_cell u_cell (
            .i_clk         (i_clk),
            .i_rst_n       (i_rst_n),
            .i_cmp_en      (w_in_accept),
            .i_cmp_value   (i_value),
            .i_cmd         (w_cell_cmd),
            .i_ins_value   (r_val),
            .i_left_value  (w_left_value),
            .i_left_valid  (w_left_valid),
            .i_left_lt     (w_left_lt),
            .i_right_value (w_right_value),
            .i_right_valid (w_right_valid),
            .o_value       (w_cell_value[gi]),
            .o_valid       (w_cell_valid[gi]),
            .o_lt          (w_cell_lt[gi]),
            .o_eq          (w_cell_eq[gi])
        );
    end

    assign o_out_valid    = r_out_valid;
    assign o_status       = r_out_status;
    assign o_result_value = r_out_value;
    assign o_held_count   = r_out_count;

    // The count never exceeds the capacity.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CAP_C)
        else $error("held count above capacity");

    // The valid cells always number exactly the held count.
    a_valid_matches_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(w_cell_valid) == 32'(r_count))
        else $error("cell valid bits disagree with held count");

    // A successful insert grows the set by one.
    a_insert_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_fire && r_op == OP_INSERT && n_status == ST_DONE)
        |=> (r_count == $past(r_count) + CW'(1)))
        else $error("insert did not grow the set");

    // A successful pop shrinks the set by one.
    a_pop_shrinks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_fire && r_op == OP_POPMIN && n_status == ST_DONE)
        |=> (r_count == $past(r_count) - CW'(1)))
        else $error("pop did not shrink the set");

endmodule

`default_nettype wire

// ===== test/ordered_set_insert_search_popmin_tb.sv =====
`timescale 1ns / 1ps

module ordered_set_insert_search_popmin_tb;

    import ospq_pkg::*;

    localparam int CAPACITY = 16;

    // The op field has one selector the block does not use; it must change nothing.
    localparam logic [1:0] OP_UNUSED = 2'd3;

    // Length of the long receiver hold-off used to back the block up.
    localparam int RX_HOLD_CYCLES = 80;

    // Cycles to wait after the last expected beat, to catch stray extra beats.
    localparam int DRAIN_CYCLES = 8;

    typedef struct {
        logic [1:0]                status;
        logic signed [VALUE_W-1:0] value;
        logic [HELD_W-1:0]         held;
    } t_set_result;

    logic                      i_clk = 1'b0;
    logic                      i_rst_n = 1'b0;
    logic                      i_in_valid = 1'b0;
    logic                      o_in_stall;
    logic [1:0]                i_op = OP_INSERT;
    logic signed [VALUE_W-1:0] i_value = '0;
    logic                      o_out_valid;
    logic                      i_out_stall = 1'b0;
    logic [1:0]                o_status;
    logic signed [VALUE_W-1:0] o_result_value;
    logic [HELD_W-1:0]         o_held_count;

    // Shadow copy of the set, kept in ascending order, and the results it predicts
    // for beats that were accepted but have not come back yet.
    logic signed [VALUE_W-1:0] shadow_set[$];
    t_set_result               awaited_results[$];
    t_set_result               oldest_result;

    int fail_count = 0;

    // Idle control. Each side draws a wait of 0 to its maximum before every beat;
    // a maximum of zero gives a stretch with no idling on that side.
    int tx_max_gap = 0;
    int rx_max_gap = 0;
    int rx_wait = 0;
    int rx_hold = 0;
    int hold_request = 0;

    ordered_set_insert_search_popmin #(
        .CAPACITY(CAPACITY)
    ) DUT (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid),
        .o_in_stall(o_in_stall),
        .i_op(i_op),
        .i_value(i_value),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_status(o_status),
        .o_result_value(o_result_value),
        .o_held_count(o_held_count)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Position of the first held value that is not less than v.
    function automatic int find_slot(input logic signed [VALUE_W-1:0] v);
        int i;
        i = 0;
        while (i < shadow_set.size() && shadow_set[i] < v)
            i++;
        return i;
    endfunction

    // Applies one accepted operation to the shadow set and queues its result.
    function automatic void apply_set_op(input logic [1:0] op,
                                         input logic signed [VALUE_W-1:0] value);
        t_set_result r;
        int pos;
        r.status = ST_MISS;
        r.value  = value;
        case (op)
            OP_INSERT: begin
                pos = find_slot(value);
                // A duplicate is reported before the full check.
                if (pos < shadow_set.size() && shadow_set[pos] == value)
                    r.status = ST_MISS;
                else if (shadow_set.size() >= CAPACITY)
                    r.status = ST_FULL;
                else begin
                    shadow_set.insert(pos, value);
                    r.status = ST_DONE;
                end
            end
            OP_SEARCH: begin
                pos = find_slot(value);
                if (pos < shadow_set.size() && shadow_set[pos] == value)
                    r.status = ST_DONE;
            end
            OP_POPMIN: begin
                if (shadow_set.size() == 0) begin
                    r.status = ST_EMPTY;
                    r.value  = EMPTY_VALUE;
                end else begin
                    r.value  = shadow_set.pop_front();
                    r.status = ST_DONE;
                end
            end
            default: begin
                // The unused selector leaves the set alone and reports a miss.
            end
        endcase
        r.held = HELD_W'(shadow_set.size());
        awaited_results.push_back(r);
    endfunction

    // Offers one beat after a random gap and holds it until the block takes it.
    // Valid is only lowered when a gap is drawn, so back-to-back beats keep it high.
    task automatic send_op(input logic [1:0] op, input logic signed [VALUE_W-1:0] value);
        int gap;
        gap = $urandom_range(tx_max_gap, 0);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_op       <= op;
        i_value    <= value;
        do @(posedge i_clk); while (o_in_stall);
        apply_set_op(op, value);
    endtask

    // Withdraws the last beat, which has been taken, and waits for every result.
    task automatic wait_drained;
        i_in_valid <= 1'b0;
        while (awaited_results.size() != 0)
            @(posedge i_clk);
    endtask

    // Receiver: checks every accepted result beat against the oldest prediction
    // and drives the stall. Outputs are read at the clock edge, before the block
    // updates them, so the check never depends on event order.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
            rx_wait = 0;
            rx_hold = 0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                if (awaited_results.size() == 0) begin
                    $error("result beat with nothing expected: status %0d value %0d held %0d",
                           o_status, o_result_value, o_held_count);
                    fail_count++;
                end else begin
                    oldest_result = awaited_results.pop_front();
                    if (o_status !== oldest_result.status) begin
                        $error("status: expected %0d, got %0d",
                               oldest_result.status, o_status);
                        fail_count++;
                    end
                    if (o_result_value !== oldest_result.value) begin
                        $error("result_value: expected %0d, got %0d",
                               oldest_result.value, o_result_value);
                        fail_count++;
                    end
                    if (o_held_count !== oldest_result.held) begin
                        $error("held_count: expected %0d, got %0d",
                               oldest_result.held, o_held_count);
                        fail_count++;
                    end
                end
                rx_wait = $urandom_range(rx_max_gap, 0);
            end
            // A long hold-off is requested by a test and counted down here.
            if (hold_request > 0) begin
                rx_hold = hold_request;
                hold_request = 0;
            end
            if (rx_hold > 0) begin
                rx_hold--;
                i_out_stall <= 1'b1;
            end else if (rx_wait > 0) begin
                rx_wait--;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    // Pop and search on an empty set, and the unused selector with nothing held.
    task automatic test_empty_set;
        tx_max_gap = 3;
        rx_max_gap = 3;
        send_op(OP_POPMIN, 32'sh1234_5678);
        send_op(OP_SEARCH, 32'sd0);
        send_op(OP_UNUSED, 32'shA5A5_5A5A);
        wait_drained();
    endtask

    // Extreme values, duplicates at both ends, hits and misses, then a full drain
    // that must come out in ascending order and end in an empty pop.
    task automatic test_extreme_values;
        tx_max_gap = 0;
        rx_max_gap = 0;
        send_op(OP_INSERT, 32'sh7FFF_FFFF);
        send_op(OP_INSERT, 32'sh8000_0000);
        send_op(OP_INSERT, 32'sd0);
        send_op(OP_INSERT, -32'sd1);
        send_op(OP_INSERT, 32'sd1);
        send_op(OP_INSERT, 32'sh8000_0000);
        send_op(OP_INSERT, 32'sh7FFF_FFFF);
        send_op(OP_SEARCH, 32'sh8000_0000);
        send_op(OP_SEARCH, 32'sh7FFF_FFFF);
        send_op(OP_SEARCH, -32'sd1);
        send_op(OP_SEARCH, 32'sd2);
        send_op(OP_UNUSED, 32'sh5A5A_A5A5);
        repeat (5) send_op(OP_POPMIN, 32'sd0);
        send_op(OP_POPMIN, -32'sd1);
        wait_drained();
    endtask

    // Fills the set, then checks a rejected insert, a duplicate into a full set,
    // a refill after a pop and a drain past empty.
    task automatic test_full_set;
        tx_max_gap = 11;
        rx_max_gap = 11;
        while (shadow_set.size() < CAPACITY)
            send_op(OP_INSERT, $urandom);
        send_op(OP_INSERT, $urandom);
        send_op(OP_INSERT, shadow_set[CAPACITY-1]);
        send_op(OP_SEARCH, shadow_set[3]);
        send_op(OP_POPMIN, $urandom);
        send_op(OP_INSERT, $urandom);
        send_op(OP_INSERT, $urandom);
        while (shadow_set.size() > 0)
            send_op(OP_POPMIN, $urandom);
        send_op(OP_POPMIN, $urandom);
        wait_drained();
    endtask

    // The receiver stalls for a long stretch while the sender keeps offering beats
    // back to back, so the block backs up and has to stall its input.
    task automatic test_backpressure;
        int round;
        int n;
        for (round = 0; round < 2; round++) begin
            tx_max_gap = 0;
            rx_max_gap = round * 11;
            @(negedge i_clk);
            hold_request = RX_HOLD_CYCLES;
            for (n = 0; n < 24; n++) begin
                if (n % 3 == 2)
                    send_op(OP_POPMIN, $urandom);
                else if (n % 3 == 1)
                    send_op(OP_SEARCH, $urandom_range(15));
                else
                    send_op(OP_INSERT, $urandom_range(15));
            end
            wait_drained();
        end
    endtask

    // Bursts of random operations. Each burst leans toward filling, draining or
    // neither, and draws values from a narrow range, the full range or the values
    // already held, so that duplicates, hits and a full set come up often.
    task automatic test_random_traffic;
        int burst;
        int n;
        int pick;
        int insert_pct;
        int pop_pct;
        int value_mode;
        logic [1:0] op;
        logic signed [VALUE_W-1:0] value;
        for (burst = 0; burst < 20; burst++) begin
            case ($urandom_range(2))
                0: begin insert_pct = 65; pop_pct = 15; end
                1: begin insert_pct = 20; pop_pct = 60; end
                default: begin insert_pct = 40; pop_pct = 30; end
            endcase
            value_mode = $urandom_range(2);
            tx_max_gap = ($urandom_range(3) == 0) ? 0 : 11;
            rx_max_gap = ($urandom_range(3) == 0) ? 0 : 11;
            for (n = 0; n < 50; n++) begin
                pick = $urandom_range(99);
                if (pick < insert_pct)
                    op = OP_INSERT;
                else if (pick < insert_pct + pop_pct)
                    op = OP_POPMIN;
                else if (pick < 96)
                    op = OP_SEARCH;
                else
                    op = OP_UNUSED;
                if (value_mode == 2 && shadow_set.size() > 0 && $urandom_range(1) == 0)
                    value = shadow_set[$urandom_range(shadow_set.size() - 1)];
                else if (value_mode == 1)
                    value = $urandom;
                else
                    value = $signed($urandom_range(16)) - 32'sd8;
                send_op(op, value);
            end
        end
        wait_drained();
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_empty_set();
        test_extreme_values();
        test_full_set();
        test_backpressure();
        test_random_traffic();

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (fail_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    // Watchdog, far beyond the slowest correct run.
    initial begin
        #2_000_000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule
